### design/kpg_pkg.sv
// ----------------------------------------------------------------------------
// Keypoint proximity grouping package
// Shared constants, register indexes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package kpg_pkg;

  localparam int unsigned PointsDef = 64;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned NumW      = 6;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CoordW-1:0] RadiusRst = 16'd160;

  localparam logic [CfgIdxW-1:0] RegRadiusX = 1'd0;
  localparam logic [CfgIdxW-1:0] RegRadiusY = 1'd1;

  typedef struct packed {
    logic accept;
    logic rd_j;
    logic rd_start;
    logic mark_link;
    logic j_clr;
    logic j_inc;
    logic write_merge;
    logic fin_load;
    logic emit_init;
    logic start_inc;
    logic grp_setup;
    logic last_upd;
    logic emit;
    logic grp_next;
    logic run_clr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic j_end;
    logic start_end;
    logic linked;
    logic done_hit;
    logic lab_match;
    logic out_free;
  } sts_t;

endpackage

### design/kpg_if.sv
// ----------------------------------------------------------------------------
// Keypoint proximity grouping channels
// Point request channel and grouped result channel.
// ----------------------------------------------------------------------------
interface kpg_in_if;
  logic                          valid;
  logic                          ready;
  logic [kpg_pkg::CoordW-1:0]    pos_x;
  logic [kpg_pkg::CoordW-1:0]    pos_y;
  logic                          final_point;

  modport source (output valid, pos_x, pos_y, final_point, input ready);
  modport sink (input valid, pos_x, pos_y, final_point, output ready);
endinterface

interface kpg_out_if;
  logic                          valid;
  logic                          ready;
  logic [kpg_pkg::NumW-1:0]      group_number;
  logic [kpg_pkg::NumW-1:0]      point_number;
  logic [kpg_pkg::CoordW-1:0]    out_x;
  logic [kpg_pkg::CoordW-1:0]    out_y;
  logic                          group_end;
  logic                          run_end;
  logic                          overflowed;

  modport source (output valid, group_number, point_number, out_x, out_y, group_end,
                  run_end, overflowed, input ready);
  modport sink (input valid, group_number, point_number, out_x, out_y, group_end,
                run_end, overflowed, output ready);
endinterface

### design/keypoint_proximity_grouping_unit.sv
// ----------------------------------------------------------------------------
// Keypoint proximity grouping unit
// Loads points, merges box-linked points into components, emits them grouped.
// ----------------------------------------------------------------------------
// Loading a point makes two sweeps over the stored points.
// A new point waits until the last is loaded; the memories have a single read port.
// Emission sweeps twice per component start: to find its last point, then to emit it.
// Reset clears count, overflow flag and control; radii reset to 160.
// Point memories hold no reset value and are only read where written.
module keypoint_proximity_grouping_unit #(
  parameter int unsigned Points = kpg_pkg::PointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kpg_in_if.sink                        in_req,
  kpg_out_if.source                     out_res,
  input  logic                          cfg_we_i,
  input  logic [kpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kpg_pkg::CoordW-1:0]    cfg_data_i
);

  kpg_pkg::cmd_t cmd;
  kpg_pkg::sts_t sts;

  kpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req.valid),
    .in_final_i (in_req.final_point),
    .in_ready_o (in_req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kpg_dp #(
    .Points (Points)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_x_i     (in_req.pos_x),
    .in_y_i     (in_req.pos_y),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_res    (out_res)
  );

endmodule

### design/kpg_ctrl.sv
// ----------------------------------------------------------------------------
// Keypoint proximity grouping controller
// Sequences loading, label merging and grouped emission.
// ----------------------------------------------------------------------------
module kpg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_final_i,
  output logic           in_ready_o,
  input  kpg_pkg::sts_t  sts_i,
  output kpg_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StP1Rd = 4'd1;
  localparam logic [3:0] StP1Ev = 4'd2;
  localparam logic [3:0] StP2Rd = 4'd3;
  localparam logic [3:0] StP2Ev = 4'd4;
  localparam logic [3:0] StSRd  = 4'd5;
  localparam logic [3:0] StSEv  = 4'd6;
  localparam logic [3:0] StFRd  = 4'd7;
  localparam logic [3:0] StFEv  = 4'd8;
  localparam logic [3:0] StORd  = 4'd9;
  localparam logic [3:0] StOEv  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       final_q, final_d;

  always_comb begin
    state_d    = state_q;
    final_d    = final_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          final_d      = in_final_i;
          if (!sts_i.full) begin
            state_d = StP1Rd;
          end else if (in_final_i) begin
            cmd_o.emit_init = 1'b1;
            state_d         = StSRd;
          end
        end
      end
      StP1Rd: begin
        if (sts_i.j_end) begin
          cmd_o.j_clr = 1'b1;
          state_d     = StP2Rd;
        end else begin
          cmd_o.rd_j = 1'b1;
          state_d    = StP1Ev;
        end
      end
      StP1Ev: begin
        cmd_o.mark_link = sts_i.linked;
        cmd_o.j_inc     = 1'b1;
        state_d         = StP1Rd;
      end
      StP2Rd: begin
        if (sts_i.j_end) begin
          cmd_o.fin_load = 1'b1;
          if (final_q) begin
            cmd_o.emit_init = 1'b1;
            state_d         = StSRd;
          end else begin
            state_d = StIdle;
          end
        end else begin
          cmd_o.rd_j = 1'b1;
          state_d    = StP2Ev;
        end
      end
      StP2Ev: begin
        cmd_o.write_merge = 1'b1;
        cmd_o.j_inc       = 1'b1;
        state_d           = StP2Rd;
      end
      StSRd: begin
        if (sts_i.start_end) begin
          cmd_o.run_clr = 1'b1;
          state_d       = StIdle;
        end else begin
          cmd_o.rd_start = 1'b1;
          state_d        = StSEv;
        end
      end
      StSEv: begin
        if (sts_i.done_hit) begin
          cmd_o.start_inc = 1'b1;
          state_d         = StSRd;
        end else begin
          cmd_o.grp_setup = 1'b1;
          state_d         = StFRd;
        end
      end
      StFRd: begin
        if (sts_i.j_end) begin
          cmd_o.grp_setup = 1'b0;
          cmd_o.j_clr     = 1'b1;
          state_d         = StORd;
        end else begin
          cmd_o.rd_j = 1'b1;
          state_d    = StFEv;
        end
      end
      StFEv: begin
        cmd_o.last_upd = sts_i.lab_match;
        cmd_o.j_inc    = 1'b1;
        state_d        = StFRd;
      end
      StORd: begin
        if (sts_i.j_end) begin
          cmd_o.grp_next = 1'b1;
          state_d        = StSRd;
        end else begin
          cmd_o.rd_j = 1'b1;
          state_d    = StOEv;
        end
      end
      StOEv: begin
        if (!sts_i.lab_match) begin
          cmd_o.j_inc = 1'b1;
          state_d     = StORd;
        end else if (sts_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.j_inc = 1'b1;
          state_d     = StORd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

endmodule

### design/kpg_dp.sv
// ----------------------------------------------------------------------------
// Keypoint proximity grouping datapath
// Point and label memories, link test, label sets and the result register.
// ----------------------------------------------------------------------------
module kpg_dp #(
  parameter int unsigned Points = kpg_pkg::PointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kpg_pkg::cmd_t                 cmd_i,
  output kpg_pkg::sts_t                 sts_o,
  input  logic [kpg_pkg::CoordW-1:0]    in_x_i,
  input  logic [kpg_pkg::CoordW-1:0]    in_y_i,
  input  logic                          cfg_we_i,
  input  logic [kpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kpg_pkg::CoordW-1:0]    cfg_data_i,
  kpg_out_if.source                     out_res
);

  localparam int unsigned IW = (Points > 1) ? $clog2(Points) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] Full = CW'(Points);

  logic [kpg_pkg::CoordW-1:0] x_mem [Points];
  logic [kpg_pkg::CoordW-1:0] y_mem [Points];
  logic [IW-1:0]              l_mem [Points];

  logic [kpg_pkg::CoordW-1:0] xr_q, yr_q;
  logic [IW-1:0]              lr_q;
  logic [kpg_pkg::CoordW-1:0] rad_x_q, rad_y_q, nx_q, ny_q;
  logic [CW-1:0]              cnt_q, j_q, start_q, emit_q;
  logic [IW-1:0]              lab_q, last_q, grp_q;
  logic                       ovf_q;
  logic [Points-1:0]          merge_q, done_q;
  logic                       ov_q;

  logic                       we;
  logic [IW-1:0]              wa, ra;
  logic [IW-1:0]              wl;
  logic [kpg_pkg::CoordW-1:0] wx, wy, dx, dy;

  assign dx = (xr_q >= nx_q) ? (xr_q - nx_q) : (nx_q - xr_q);
  assign dy = (yr_q >= ny_q) ? (yr_q - ny_q) : (ny_q - yr_q);

  assign sts_o.full      = (cnt_q == Full);
  assign sts_o.j_end     = (j_q == cnt_q);
  assign sts_o.start_end = (start_q == cnt_q);
  assign sts_o.linked    = (dx < rad_x_q) && (dy < rad_y_q);
  assign sts_o.done_hit  = done_q[lr_q];
  assign sts_o.lab_match = (lr_q == lab_q);
  assign sts_o.out_free  = !ov_q || out_res.ready;

  always_comb begin
    we = 1'b0;
    wa = cnt_q[IW-1:0];
    wl = cnt_q[IW-1:0];
    wx = in_x_i;
    wy = in_y_i;
    if (cmd_i.accept && !sts_o.full) begin
      we = 1'b1;
    end else if (cmd_i.write_merge && merge_q[lr_q]) begin
      we = 1'b1;
      wa = j_q[IW-1:0];
      wx = xr_q;
      wy = yr_q;
    end
    ra = cmd_i.rd_start ? start_q[IW-1:0] : j_q[IW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      x_mem[wa] <= wx;
      y_mem[wa] <= wy;
      l_mem[wa] <= wl;
    end
    if (cmd_i.rd_j || cmd_i.rd_start) begin
      xr_q <= x_mem[ra];
      yr_q <= y_mem[ra];
      lr_q <= l_mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      nx_q <= in_x_i;
      ny_q <= in_y_i;
    end
    if (cmd_i.grp_setup) begin
      lab_q <= lr_q;
    end
    if (cmd_i.grp_setup || cmd_i.last_upd) begin
      last_q <= cmd_i.grp_setup ? start_q[IW-1:0] : j_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_x_q <= kpg_pkg::RadiusRst;
      rad_y_q <= kpg_pkg::RadiusRst;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      j_q     <= '0;
      start_q <= '0;
      emit_q  <= '0;
      grp_q   <= '0;
      merge_q <= '0;
      done_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == kpg_pkg::RegRadiusX) begin
        rad_x_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == kpg_pkg::RegRadiusY) begin
        rad_y_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        if (sts_o.full) begin
          ovf_q <= 1'b1;
        end
        merge_q <= '0;
        j_q     <= '0;
      end
      if (cmd_i.mark_link) begin
        merge_q[lr_q] <= 1'b1;
      end
      if (cmd_i.j_clr) begin
        j_q <= cmd_i.grp_setup ? start_q : start_q;
      end else if (cmd_i.grp_setup) begin
        j_q <= start_q;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.fin_load) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.emit_init) begin
        start_q <= '0;
        emit_q  <= '0;
        grp_q   <= '0;
        done_q  <= '0;
      end
      if (cmd_i.start_inc || cmd_i.grp_next) begin
        start_q <= start_q + 1'b1;
      end
      if (cmd_i.grp_next) begin
        grp_q <= grp_q + 1'b1;
      end
      if (cmd_i.grp_setup) begin
        done_q[lr_q] <= 1'b1;
      end
      if (cmd_i.emit) begin
        emit_q <= emit_q + 1'b1;
      end
      if (cmd_i.run_clr) begin
        cnt_q   <= '0;
        ovf_q   <= 1'b0;
        start_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (out_res.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_res.group_number <= kpg_pkg::NumW'(grp_q);
      out_res.point_number <= kpg_pkg::NumW'(j_q);
      out_res.out_x        <= xr_q;
      out_res.out_y        <= yr_q;
      out_res.group_end    <= (j_q[IW-1:0] == last_q);
      out_res.run_end      <= (emit_q == cnt_q - 1'b1);
      out_res.overflowed   <= ovf_q;
    end
  end

  assign out_res.valid = ov_q;

endmodule
